// File: rtl/detr_pkg.sv
// Types and constants shared by the dual energy total restore block.
`timescale 1ns / 1ps
package detr_pkg;

   // Fixed field widths of the cell item and the result item.
   localparam int VAL_W = 32;
   localparam int CRD_W = 10;
   localparam int DIM_W = 11;
   localparam int GW_W  = 4;
   localparam int IDX_W = 3;
   localparam int CSR_W = 11;

   // Magnetic quotient: bits kept and the clamp applied to it.
   localparam int QUO_W     = 52;
   localparam int CLAMP_LOG = 50;
   localparam int DEN_W     = 33;

   // Register indexes of the configuration port.
   localparam logic [IDX_W-1:0] CSR_REGION_MODE = 3'd0;
   localparam logic [IDX_W-1:0] CSR_GRID_RANK   = 3'd1;
   localparam logic [IDX_W-1:0] CSR_MHD_ENABLE  = 3'd2;
   localparam logic [IDX_W-1:0] CSR_DUAL_ENABLE = 3'd3;
   localparam logic [IDX_W-1:0] CSR_DIM_X       = 3'd4;
   localparam logic [IDX_W-1:0] CSR_DIM_Y       = 3'd5;
   localparam logic [IDX_W-1:0] CSR_DIM_Z       = 3'd6;
   localparam logic [IDX_W-1:0] CSR_GHOST_WIDTH = 3'd7;

   typedef struct packed {
      logic [CRD_W-1:0]        cell_x;
      logic [CRD_W-1:0]        cell_y;
      logic [CRD_W-1:0]        cell_z;
      logic signed [VAL_W-1:0] old_total_energy;
      logic signed [VAL_W-1:0] internal_energy;
      logic signed [VAL_W-1:0] vel_a;
      logic signed [VAL_W-1:0] vel_b;
      logic signed [VAL_W-1:0] vel_c;
      logic signed [VAL_W-1:0] mag_a;
      logic signed [VAL_W-1:0] mag_b;
      logic signed [VAL_W-1:0] mag_c;
      logic signed [VAL_W-1:0] density;
   } req_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] total_energy;
      logic                    recomputed;
      logic                    overflow;
   } rsp_type;

   // Per-item control that travels with the data down the pipeline.
   typedef struct packed {
      logic                    doit;
      logic                    mhd;
      logic                    rho_neg;
      logic                    rho_zero;
      logic signed [VAL_W-1:0] old_e;
   } side_type;

endpackage

// File: rtl/dual_energy_total_restore.sv
// Top level: pipelined total energy rebuild with a bit-per-stage divider.
`timescale 1ns / 1ps
//
// Usage: cell items enter on the req_ channel (valid/ready) and one result
// item per cell leaves on the rsp_ channel in the same order. The csr_ port
// is a plain write port (csr_we, csr_index, csr_wdata) for the eight
// configuration registers; write it only while no item is in flight.
// Structure: 58 register stages (decode, multiply, sum, 53 divider stages,
// magnetic term, saturation).
// Throughput: one item per cycle while rsp_ready does not stall the output,
// set by a pipeline in which every stage, including each step of the
// restoring divider for B squared over twice the density, is its own
// register stage.
// Stall: when the receiver holds rsp_ready low with a result waiting, the
// whole pipeline freezes and req_ready drops; nothing is lost or repeated.
// Reset (synchronous, active high) empties the pipeline and loads the
// registers with: whole-grid mode, rank 3, MHD off, dual energy on,
// 64 cells per axis and a ghost width of 3.
//
module dual_energy_total_restore #(
   parameter int DIM_MAX   = 1024,
   parameter int FRAC_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  detr_pkg::req_type           req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output detr_pkg::rsp_type           rsp_data,
   input  logic                        csr_we,
   input  logic [detr_pkg::IDX_W-1:0]  csr_index,
   input  logic [detr_pkg::CSR_W-1:0]  csr_wdata
);
   import detr_pkg::*;

   localparam int CD_W   = $clog2(DIM_MAX + 1);
   localparam int CMP_W  = (CD_W > DIM_W ? CD_W : DIM_W) + 1;
   localparam int KIN_W  = 2 * VAL_W - FRAC_BITS - 1;
   localparam int SUM_W  = (KIN_W > CLAMP_LOG + 1 ? KIN_W : CLAMP_LOG + 1) + 4;

   // Configuration registers.
   logic                 region_mode_ff;
   logic [1:0]           grid_rank_ff;
   logic                 mhd_enable_ff;
   logic                 dual_enable_ff;
   logic [DIM_W-1:0]     dim_x_ff, dim_y_ff, dim_z_ff;
   logic [GW_W-1:0]      ghost_width_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         region_mode_ff <= 1'b0;
         grid_rank_ff   <= 2'd3;
         mhd_enable_ff  <= 1'b0;
         dual_enable_ff <= 1'b1;
         dim_x_ff       <= DIM_W'(64);
         dim_y_ff       <= DIM_W'(64);
         dim_z_ff       <= DIM_W'(64);
         ghost_width_ff <= GW_W'(3);
      end else if (csr_we) begin
         case (csr_index)
            CSR_REGION_MODE: region_mode_ff <= csr_wdata[0];
            CSR_GRID_RANK:   grid_rank_ff   <= csr_wdata[1:0];
            CSR_MHD_ENABLE:  mhd_enable_ff  <= csr_wdata[0];
            CSR_DUAL_ENABLE: dual_enable_ff <= csr_wdata[0];
            CSR_DIM_X:       dim_x_ff       <= csr_wdata[DIM_W-1:0];
            CSR_DIM_Y:       dim_y_ff       <= csr_wdata[DIM_W-1:0];
            CSR_DIM_Z:       dim_z_ff       <= csr_wdata[DIM_W-1:0];
            CSR_GHOST_WIDTH: ghost_width_ff <= csr_wdata[GW_W-1:0];
            default: ;
         endcase
      end
   end

   // Ghost shell test for one axis: below the ghost width or within it of the end.
   function automatic logic is_ghost(input logic [CRD_W-1:0] idx,
                                     input logic [DIM_W-1:0] dim,
                                     input logic [GW_W-1:0]  gw,
                                     input logic             act);
      logic [CMP_W-1:0] cd;
      logic [CMP_W-1:0] g;
      logic [CMP_W-1:0] lhs;
      if (dim == '0)
         cd = CMP_W'(1);
      else if (CMP_W'(dim) > CMP_W'(DIM_MAX))
         cd = CMP_W'(DIM_MAX);
      else
         cd = CMP_W'(dim);
      g   = act ? CMP_W'(gw) : '0;
      lhs = CMP_W'(idx) + CMP_W'(1) + g;
      return (CMP_W'(idx) < g) || (lhs > cd);
   endfunction

   function automatic logic [VAL_W-1:0] mag32(input logic signed [VAL_W-1:0] v);
      return v[VAL_W-1] ? VAL_W'(-v) : VAL_W'(v);
   endfunction

   // The whole pipeline moves when the output register is free or drained.
   logic advance;
   logic rsp_valid_ff;
   rsp_type rsp_data_ff;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   // Stage 1: region decode, magnitudes and rank masking.
   logic             rank2, rank3, in_shell, doit_in;
   logic             s1_vld_ff;
   side_type         s1_side_ff;
   logic signed [VAL_W-1:0] s1_eint_ff;
   logic [VAL_W-1:0] s1_va_ff, s1_vb_ff, s1_vc_ff;
   logic [VAL_W-1:0] s1_ba_ff, s1_bb_ff, s1_bc_ff, s1_rho_ff;
   side_type         s1_side_in;

   always_comb begin
      rank2    = grid_rank_ff >= 2'd2;
      rank3    = grid_rank_ff == 2'd3;
      in_shell = is_ghost(req_data.cell_x, dim_x_ff, ghost_width_ff, 1'b1) ||
                 is_ghost(req_data.cell_y, dim_y_ff, ghost_width_ff, rank2) ||
                 is_ghost(req_data.cell_z, dim_z_ff, ghost_width_ff, rank3);
      doit_in  = dual_enable_ff && (!region_mode_ff || in_shell);
      s1_side_in.doit     = doit_in;
      s1_side_in.mhd      = mhd_enable_ff;
      s1_side_in.rho_neg  = req_data.density[VAL_W-1];
      s1_side_in.rho_zero = req_data.density == '0;
      s1_side_in.old_e    = req_data.old_total_energy;
   end

   always_ff @(posedge clock) begin
      if (reset)
         s1_vld_ff <= 1'b0;
      else if (advance)
         s1_vld_ff <= req_valid;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_side_ff <= s1_side_in;
         s1_eint_ff <= req_data.internal_energy;
         s1_va_ff   <= mag32(req_data.vel_a);
         s1_vb_ff   <= rank2 ? mag32(req_data.vel_b) : '0;
         s1_vc_ff   <= rank3 ? mag32(req_data.vel_c) : '0;
         s1_ba_ff   <= mag32(req_data.mag_a);
         s1_bb_ff   <= mag32(req_data.mag_b);
         s1_bc_ff   <= mag32(req_data.mag_c);
         s1_rho_ff  <= mag32(req_data.density);
      end
   end

   // Stage 2: the six squares.
   logic                    s2_vld_ff;
   side_type                s2_side_ff;
   logic signed [VAL_W-1:0] s2_eint_ff;
   logic [2*VAL_W-1:0]      s2_sva_ff, s2_svb_ff, s2_svc_ff;
   logic [2*VAL_W-1:0]      s2_sba_ff, s2_sbb_ff, s2_sbc_ff;
   logic [VAL_W-1:0]        s2_rho_ff;

   always_ff @(posedge clock) begin
      if (reset)
         s2_vld_ff <= 1'b0;
      else if (advance)
         s2_vld_ff <= s1_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_side_ff <= s1_side_ff;
         s2_eint_ff <= s1_eint_ff;
         s2_sva_ff  <= s1_va_ff * s1_va_ff;
         s2_svb_ff  <= s1_vb_ff * s1_vb_ff;
         s2_svc_ff  <= s1_vc_ff * s1_vc_ff;
         s2_sba_ff  <= s1_ba_ff * s1_ba_ff;
         s2_sbb_ff  <= s1_bb_ff * s1_bb_ff;
         s2_sbc_ff  <= s1_bc_ff * s1_bc_ff;
         s2_rho_ff  <= s1_rho_ff;
      end
   end

   // Stage 3: base sum of internal and kinetic energy, B squared, divisor.
   logic                    s3_vld_ff;
   side_type                s3_side_ff;
   logic signed [SUM_W-1:0] s3_base_ff;
   logic [2*VAL_W-1:0]      s3_b2_ff;
   logic [DEN_W-1:0]        s3_den_ff;
   logic signed [SUM_W-1:0] base_in;

   always_comb begin
      base_in = SUM_W'(s2_eint_ff) +
                $signed(SUM_W'(s2_sva_ff >> (FRAC_BITS + 1))) +
                $signed(SUM_W'(s2_svb_ff >> (FRAC_BITS + 1))) +
                $signed(SUM_W'(s2_svc_ff >> (FRAC_BITS + 1)));
   end

   always_ff @(posedge clock) begin
      if (reset)
         s3_vld_ff <= 1'b0;
      else if (advance)
         s3_vld_ff <= s2_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_side_ff <= s2_side_ff;
         s3_base_ff <= base_in;
         s3_b2_ff   <= s2_sba_ff + s2_sbb_ff + s2_sbc_ff;
         s3_den_ff  <= {s2_rho_ff, 1'b0};
      end
   end

   // Divider: stage 0 checks for a quotient beyond the kept bits, then one
   // restoring step per stage brings in one dividend bit.
   logic                    dv_vld_ff  [0:QUO_W];
   side_type                dv_side_ff [0:QUO_W];
   logic signed [SUM_W-1:0] dv_base_ff [0:QUO_W];
   logic [DEN_W-1:0]        dv_den_ff  [0:QUO_W];
   logic                    dv_big_ff  [0:QUO_W];
   logic [DEN_W-1:0]        dv_rem_ff  [0:QUO_W];
   logic [QUO_W-1:0]        dv_low_ff  [0:QUO_W];
   logic [QUO_W-1:0]        dv_quo_ff  [0:QUO_W];

   logic [DEN_W:0]          dv_trial   [1:QUO_W];
   logic                    dv_ge      [1:QUO_W];

   always_comb begin
      for (int j = 1; j <= QUO_W; j++) begin
         dv_trial[j] = {dv_rem_ff[j-1], dv_low_ff[j-1][QUO_W-1]};
         dv_ge[j]    = dv_trial[j] >= {1'b0, dv_den_ff[j-1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j <= QUO_W; j++)
            dv_vld_ff[j] <= 1'b0;
      end else if (advance) begin
         dv_vld_ff[0] <= s3_vld_ff;
         for (int j = 1; j <= QUO_W; j++)
            dv_vld_ff[j] <= dv_vld_ff[j-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dv_side_ff[0] <= s3_side_ff;
         dv_base_ff[0] <= s3_base_ff;
         dv_den_ff[0]  <= s3_den_ff;
         dv_big_ff[0]  <= DEN_W'(s3_b2_ff[2*VAL_W-1:QUO_W]) >= s3_den_ff;
         dv_rem_ff[0]  <= DEN_W'(s3_b2_ff[2*VAL_W-1:QUO_W]);
         dv_low_ff[0]  <= s3_b2_ff[QUO_W-1:0];
         dv_quo_ff[0]  <= '0;
         for (int j = 1; j <= QUO_W; j++) begin
            dv_side_ff[j] <= dv_side_ff[j-1];
            dv_base_ff[j] <= dv_base_ff[j-1];
            dv_den_ff[j]  <= dv_den_ff[j-1];
            dv_big_ff[j]  <= dv_big_ff[j-1];
            dv_rem_ff[j]  <= dv_ge[j] ? DEN_W'(dv_trial[j] - {1'b0, dv_den_ff[j-1]})
                                      : DEN_W'(dv_trial[j]);
            dv_low_ff[j]  <= {dv_low_ff[j-1][QUO_W-2:0], 1'b0};
            dv_quo_ff[j]  <= {dv_quo_ff[j-1][QUO_W-2:0], dv_ge[j]};
         end
      end
   end

   // Clamped, signed magnetic term.
   logic                    f1_vld_ff;
   side_type                f1_side_ff;
   logic signed [SUM_W-1:0] f1_base_ff;
   logic signed [SUM_W-1:0] f1_mag_ff;
   logic [CLAMP_LOG:0]      q_clamp;
   logic signed [SUM_W-1:0] mag_in;

   always_comb begin
      if (dv_big_ff[QUO_W] ||
          dv_quo_ff[QUO_W] > QUO_W'({1'b1, {CLAMP_LOG{1'b0}}}))
         q_clamp = {1'b1, {CLAMP_LOG{1'b0}}};
      else
         q_clamp = dv_quo_ff[QUO_W][CLAMP_LOG:0];
      if (!dv_side_ff[QUO_W].mhd)
         mag_in = '0;
      else if (dv_side_ff[QUO_W].rho_neg)
         mag_in = -$signed(SUM_W'(q_clamp));
      else
         mag_in = $signed(SUM_W'(q_clamp));
   end

   always_ff @(posedge clock) begin
      if (reset)
         f1_vld_ff <= 1'b0;
      else if (advance)
         f1_vld_ff <= dv_vld_ff[QUO_W];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         f1_side_ff <= dv_side_ff[QUO_W];
         f1_base_ff <= dv_base_ff[QUO_W];
         f1_mag_ff  <= mag_in;
      end
   end

   // Final sum, saturation and choice of result into the output register.
   localparam logic signed [SUM_W-1:0] S32_MAX = SUM_W'(64'sh7FFF_FFFF);
   localparam logic signed [SUM_W-1:0] S32_MIN = -SUM_W'(64'sh8000_0000);

   logic signed [SUM_W-1:0] total_sum;
   rsp_type                 rsp_in;

   always_comb begin
      total_sum = f1_base_ff + f1_mag_ff;
      if (!f1_side_ff.doit) begin
         rsp_in.total_energy = f1_side_ff.old_e;
         rsp_in.recomputed   = 1'b0;
         rsp_in.overflow     = 1'b0;
      end else if (f1_side_ff.mhd && f1_side_ff.rho_zero) begin
         rsp_in.total_energy = 32'sh7FFF_FFFF;
         rsp_in.recomputed   = 1'b1;
         rsp_in.overflow     = 1'b1;
      end else if (total_sum > S32_MAX) begin
         rsp_in.total_energy = 32'sh7FFF_FFFF;
         rsp_in.recomputed   = 1'b1;
         rsp_in.overflow     = 1'b1;
      end else if (total_sum < S32_MIN) begin
         rsp_in.total_energy = 32'sh8000_0000;
         rsp_in.recomputed   = 1'b1;
         rsp_in.overflow     = 1'b1;
      end else begin
         rsp_in.total_energy = VAL_W'(total_sum);
         rsp_in.recomputed   = 1'b1;
         rsp_in.overflow     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (advance)
         rsp_valid_ff <= f1_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (advance)
         rsp_data_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   // A passed-through item never reports overflow.
   a_pass_no_ovf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.recomputed |-> !rsp_data_ff.overflow)
      else $error("pass-through item flagged overflow");

   // An overflowing result is pinned at one of the two limits.
   a_ovf_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.overflow |->
         (rsp_data_ff.total_energy == 32'sh7FFF_FFFF) ||
         (rsp_data_ff.total_energy == 32'sh8000_0000))
      else $error("overflow without saturated total");

   // The divider's final remainder stays below the divisor.
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      dv_vld_ff[QUO_W] && !dv_big_ff[QUO_W] && dv_side_ff[QUO_W].mhd &&
      !dv_side_ff[QUO_W].rho_zero |-> dv_rem_ff[QUO_W] < dv_den_ff[QUO_W])
      else $error("divider remainder out of range");

   // A stall freezes the item at the divider's end.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(dv_vld_ff[QUO_W]) && $stable(f1_vld_ff))
      else $error("pipeline moved during stall");
`endif

endmodule
